>>> hw/rtl/eft_pkg.sv
// Package for the Euler frame change transform: codes, state and step types,
// default widths and the constants of the sine and cosine series.
// No dependencies.
`timescale 1ns / 1ps
package eft_pkg;

  // Default widths handed to the top level parameters
  localparam int COORD_WIDTH_DEF    = 32;
  localparam int ANGLE_WIDTH_DEF    = 16;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Height offset register, Q16.16 metres (0.4 m after reset)
  localparam logic [31:0] HEIGHT_OFFSET_RST = 32'd26214;

  // Item modes
  localparam logic [1:0] MODE_POSE = 2'd0;
  localparam logic [1:0] MODE_VEL  = 2'd1;
  localparam logic [1:0] MODE_TPOS = 2'd2;
  localparam logic [1:0] MODE_TVEL = 2'd3;

  // Result kinds
  localparam logic KIND_POS = 1'b0;
  localparam logic KIND_VEL = 1'b1;

  // Q30 constants of the series
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Reciprocals for exact floor division of values below 2^30:
  // ceil(2^(30+l) / d) with l = ceil(log2(d))
  localparam logic [30:0] RCP_DIV42 = 31'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [30:0] RCP_DIV20 = 31'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [30:0] RCP_DIV6  = 31'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [30:0] RCP_DIV56 = 31'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [30:0] RCP_DIV30 = 31'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [30:0] RCP_DIV12 = 31'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [30:0] RCP_DIV2  = 31'(((64'd1 << 31) + 64'd1) / 64'd2);

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TRIG_SET,
    BK_TRIG_MUL,
    BK_TRIG_POST,
    BK_TRIG_DONE,
    BK_MAT_MUL,
    BK_MAT_POST,
    BK_XF_MUL,
    BK_XF_POST,
    BK_XF_RND,
    BK_EMIT
  } back_state_t;

  // Steps of the sine and cosine series, one multiply each
  typedef enum logic [3:0] {
    TS_X, TS_X2, TS_S1, TS_S1W, TS_S2, TS_S2W, TS_S3, TS_SIN,
    TS_C1, TS_C1W, TS_C2, TS_C2W, TS_C3, TS_C3W, TS_C4
  } trig_step_t;

  typedef enum logic [2:0] {
    CS_SPH, CS_CPH, CS_STH, CS_CTH, CS_SPS, CS_CPS, CS_A, CS_B
  } coef_sel_t;

  typedef enum logic [1:0] {MD_A, MD_B, MD_ACC, MD_ROT} mat_dst_t;
  typedef enum logic [1:0] {MM_SET, MM_ADD, MM_SUB} mat_mode_t;

  typedef struct packed {
    coef_sel_t  sel_a;
    coef_sel_t  sel_b;
    mat_dst_t   dst;
    logic [3:0] rot_idx;
    mat_mode_t  mode;
  } mat_op_t;

  localparam logic [3:0] MAT_LAST = 4'd13;

  // Matrix build program: one rounded product per step
  function automatic mat_op_t mat_prog(input logic [3:0] step);
    mat_op_t op;
    op = '{sel_a: CS_CPS, sel_b: CS_STH, dst: MD_A, rot_idx: 4'd0, mode: MM_SET};
    case (step)
      4'd0:  op = '{CS_CPS, CS_STH, MD_A,   4'd0, MM_SET};
      4'd1:  op = '{CS_SPS, CS_STH, MD_B,   4'd0, MM_SET};
      4'd2:  op = '{CS_CPS, CS_CTH, MD_ROT, 4'd0, MM_SET};
      4'd3:  op = '{CS_A,   CS_SPH, MD_ACC, 4'd0, MM_SET};
      4'd4:  op = '{CS_SPS, CS_CPH, MD_ROT, 4'd1, MM_SUB};
      4'd5:  op = '{CS_A,   CS_CPH, MD_ACC, 4'd0, MM_SET};
      4'd6:  op = '{CS_SPS, CS_SPH, MD_ROT, 4'd2, MM_ADD};
      4'd7:  op = '{CS_SPS, CS_CTH, MD_ROT, 4'd3, MM_SET};
      4'd8:  op = '{CS_B,   CS_SPH, MD_ACC, 4'd0, MM_SET};
      4'd9:  op = '{CS_CPS, CS_CPH, MD_ROT, 4'd4, MM_ADD};
      4'd10: op = '{CS_B,   CS_CPH, MD_ACC, 4'd0, MM_SET};
      4'd11: op = '{CS_CPS, CS_SPH, MD_ROT, 4'd5, MM_SUB};
      4'd12: op = '{CS_CTH, CS_SPH, MD_ROT, 4'd7, MM_SET};
      4'd13: op = '{CS_CTH, CS_CPH, MD_ROT, 4'd8, MM_SET};
      default: op = '{CS_CPS, CS_STH, MD_A, 4'd0, MM_SET};
    endcase
    return op;
  endfunction

endpackage

>>> hw/rtl/eft_queue.sv
// Two-entry queue of flat words, used between the parts of the transform.
// Depends on nothing.
`timescale 1ns / 1ps
module eft_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  logic [WIDTH-1:0] mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       do_push, do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule

>>> hw/rtl/eft_front.sv
// Front part: holds the height offset register, accepts items, applies the
// offset to target positions and queues items for the back part.
// Depends on eft_pkg and eft_queue.
`timescale 1ns / 1ps
module eft_front
  import eft_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [31:0]            cfg_data,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_mode,
  input  logic [COORD_WIDTH-1:0] in_vec_x,
  input  logic [COORD_WIDTH-1:0] in_vec_y,
  input  logic [COORD_WIDTH-1:0] in_vec_z,
  input  logic [ANGLE_WIDTH-1:0] in_roll_angle,
  input  logic [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic [ANGLE_WIDTH-1:0] in_yaw_angle,
  output logic                   item_valid,
  input  logic                   item_take,
  output logic [1:0]             item_mode,
  output logic [COORD_WIDTH-1:0] item_x,
  output logic [COORD_WIDTH-1:0] item_y,
  output logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32):0] item_z,
  output logic [ANGLE_WIDTH-1:0] item_roll,
  output logic [ANGLE_WIDTH-1:0] item_pitch,
  output logic [ANGLE_WIDTH-1:0] item_yaw
);
  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int ZW = ((CW > 32) ? CW : 32) + 1;
  localparam int IW = 2 + 2 * CW + ZW + 3 * AW;

  logic [31:0]          ho_r;
  logic signed [ZW-1:0] z_ext, ho_ext, z_adj;
  logic [IW-1:0]        din, dout;
  logic                 q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ho_r <= HEIGHT_OFFSET_RST;
    end else if (cfg_valid) begin
      ho_r <= cfg_data;
    end
  end

  // Target positions carry the height offset on z
  assign z_ext  = $signed({{(ZW - CW){in_vec_z[CW-1]}}, in_vec_z});
  assign ho_ext = $signed({{(ZW - 32){ho_r[31]}}, ho_r});
  assign z_adj  = (in_mode == MODE_TPOS) ? z_ext + ho_ext : z_ext;

  assign din = {in_mode, in_vec_x, in_vec_y, z_adj,
                in_roll_angle, in_pitch_angle, in_yaw_angle};

  eft_queue #(.WIDTH(IW)) u_itemq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (din),
    .full  (in_full),
    .pop   (item_take),
    .dout  (dout),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;
  assign {item_mode, item_x, item_y, item_z, item_roll, item_pitch, item_yaw} = dout;
endmodule

>>> hw/rtl/eft_back.sv
// Back part: sine and cosine series, rotation matrix build and the
// transposed-matrix transform, all through one shared multiplier.
// Depends on eft_pkg.
`timescale 1ns / 1ps
module eft_back
  import eft_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   item_valid,
  output logic                   item_take,
  input  logic [1:0]             item_mode,
  input  logic [COORD_WIDTH-1:0] item_x,
  input  logic [COORD_WIDTH-1:0] item_y,
  input  logic [((COORD_WIDTH > 32) ? COORD_WIDTH : 32):0] item_z,
  input  logic [ANGLE_WIDTH-1:0] item_roll,
  input  logic [ANGLE_WIDTH-1:0] item_pitch,
  input  logic [ANGLE_WIDTH-1:0] item_yaw,
  input  logic                   res_full,
  output logic                   res_push,
  output logic                   res_kind,
  output logic [COORD_WIDTH-1:0] res_x,
  output logic [COORD_WIDTH-1:0] res_y,
  output logic [COORD_WIDTH-1:0] res_z
);
  localparam int CW  = COORD_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int F   = COEF_FRAC_BITS;
  localparam int ZW  = ((CW > 32) ? CW : 32) + 1;
  localparam int DW  = ZW + 1;
  localparam int CFW = F + 2;
  localparam int PW  = DW + 33;
  localparam int SW  = DW + F + 4;

  localparam logic signed [PW-1:0]  MHALF   = PW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0]  XHALF   = SW'(64'sd1 <<< (F - 1));
  localparam logic signed [SW-1:0]  SAT_HI  = SW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]  SAT_LO  = -SAT_HI - SW'(1);
  localparam logic signed [F+2:0]   COEF_ONE = {3'b001, {F{1'b0}}};
  localparam logic signed [CFW-1:0] ROT_ONE  = {2'b01, {F{1'b0}}};
  localparam logic [31:0]           SC_HALF  = 32'(64'd1 << (29 - F));

  back_state_t state_r, state_nxt;

  logic [1:0]             mode_r;
  logic [AW-1:0]          ang_r [3];
  logic signed [DW-1:0]   d_r [3];
  logic signed [CW-1:0]   pos_r [3];
  logic signed [CW-1:0]   vel_r [3];
  logic signed [CFW-1:0]  rot_r [9];
  logic signed [CFW-1:0]  sph_r, cph_r, sth_r, cth_r, sps_r, cps_r, a_r, b_r;
  logic signed [F+2:0]    macc_r;
  trig_step_t             ts_r;
  logic [1:0]             ang_idx_r, quad_r;
  logic                   fold_r;
  logic [29:0]            r_r, x_r, x2_r, w_r;
  logic [30:0]            t_r, u_r;
  logic [3:0]             ms_r;
  logic [1:0]             xi_r, xj_r;
  logic signed [SW-1:0]   xacc_r;
  logic signed [CW-1:0]   res_r [3];
  logic signed [PW-1:0]   prod_r;

  logic signed [DW-1:0]   opa;
  logic signed [32:0]     opb;
  logic signed [PW-1:0]   prod;
  mat_op_t                mop;
  logic signed [CFW-1:0]  coef_a, coef_b;
  logic [3:0]             rot_idx;
  logic [31:0]            phase;
  logic [29:0]            frac, r_fold;
  logic                   fold;
  logic [31:0]            s_sum, c_sum;
  logic signed [CFW-1:0]  sq, cq, sv, cv, sin_fin, cos_fin;
  logic signed [PW-1:0]   m_full;
  logic signed [F+2:0]    mq, msum;
  logic signed [CFW-1:0]  mclamp;
  logic signed [SW-1:0]   xr, xsat;
  logic signed [DW-1:0]   vx, vy, vz, bx, by, bz;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (item_valid) begin
          case (item_mode)
            MODE_POSE: state_nxt = BK_TRIG_SET;
            MODE_VEL:  state_nxt = BK_IDLE;
            default:   state_nxt = BK_XF_MUL;
          endcase
        end
      end
      BK_TRIG_SET:  state_nxt = BK_TRIG_MUL;
      BK_TRIG_MUL:  state_nxt = BK_TRIG_POST;
      BK_TRIG_POST: state_nxt = (ts_r == TS_C4) ? BK_TRIG_DONE : BK_TRIG_MUL;
      BK_TRIG_DONE: state_nxt = (ang_idx_r == 2'd2) ? BK_MAT_MUL : BK_TRIG_SET;
      BK_MAT_MUL:   state_nxt = BK_MAT_POST;
      BK_MAT_POST:  state_nxt = (ms_r == MAT_LAST) ? BK_IDLE : BK_MAT_MUL;
      BK_XF_MUL:    state_nxt = BK_XF_POST;
      BK_XF_POST:   state_nxt = (xj_r == 2'd2) ? BK_XF_RND : BK_XF_MUL;
      BK_XF_RND:    state_nxt = (xi_r == 2'd2) ? BK_EMIT : BK_XF_MUL;
      BK_EMIT:      state_nxt = res_full ? BK_EMIT : BK_IDLE;
      default:      state_nxt = BK_IDLE;
    endcase
  end

  // Outputs and multiplier operands
  always_comb begin
    item_take = (state_r == BK_IDLE) && item_valid;
    res_push  = (state_r == BK_EMIT) && !res_full;
    opa = '0;
    opb = '0;
    case (state_r)
      BK_TRIG_MUL: begin
        case (ts_r)
          TS_X:   begin opa = $signed({{(DW-30){1'b0}}, r_r});  opb = $signed({1'b0, PI_Q30}); end
          TS_X2:  begin opa = $signed({{(DW-30){1'b0}}, x_r});  opb = $signed({3'b0, x_r}); end
          TS_S1:  begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, RCP_DIV42}); end
          TS_S1W: begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, t_r}); end
          TS_S2:  begin opa = $signed({{(DW-30){1'b0}}, w_r});  opb = $signed({2'b0, RCP_DIV20}); end
          TS_S2W: begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, t_r}); end
          TS_S3:  begin opa = $signed({{(DW-30){1'b0}}, w_r});  opb = $signed({2'b0, RCP_DIV6}); end
          TS_SIN: begin opa = $signed({{(DW-30){1'b0}}, x_r});  opb = $signed({2'b0, t_r}); end
          TS_C1:  begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, RCP_DIV56}); end
          TS_C1W: begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, u_r}); end
          TS_C2:  begin opa = $signed({{(DW-30){1'b0}}, w_r});  opb = $signed({2'b0, RCP_DIV30}); end
          TS_C2W: begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, u_r}); end
          TS_C3:  begin opa = $signed({{(DW-30){1'b0}}, w_r});  opb = $signed({2'b0, RCP_DIV12}); end
          TS_C3W: begin opa = $signed({{(DW-30){1'b0}}, x2_r}); opb = $signed({2'b0, u_r}); end
          TS_C4:  begin opa = $signed({{(DW-30){1'b0}}, w_r});  opb = $signed({2'b0, RCP_DIV2}); end
          default: begin opa = '0; opb = '0; end
        endcase
      end
      BK_MAT_MUL: begin
        opa = $signed({{(DW-CFW){coef_a[CFW-1]}}, coef_a});
        opb = $signed({{(33-CFW){coef_b[CFW-1]}}, coef_b});
      end
      BK_XF_MUL: begin
        opa = d_r[xj_r];
        opb = $signed({{(33-CFW){rot_r[rot_idx][CFW-1]}}, rot_r[rot_idx]});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod = opa * opb;
  assign mop  = mat_prog(ms_r);

  always_comb begin
    case (mop.sel_a)
      CS_SPH:  coef_a = sph_r;
      CS_CPH:  coef_a = cph_r;
      CS_STH:  coef_a = sth_r;
      CS_CTH:  coef_a = cth_r;
      CS_SPS:  coef_a = sps_r;
      CS_CPS:  coef_a = cps_r;
      CS_A:    coef_a = a_r;
      CS_B:    coef_a = b_r;
      default: coef_a = a_r;
    endcase
    case (mop.sel_b)
      CS_SPH:  coef_b = sph_r;
      CS_CPH:  coef_b = cph_r;
      CS_STH:  coef_b = sth_r;
      CS_CTH:  coef_b = cth_r;
      CS_SPS:  coef_b = sps_r;
      CS_CPS:  coef_b = cps_r;
      CS_A:    coef_b = a_r;
      CS_B:    coef_b = b_r;
      default: coef_b = b_r;
    endcase
  end

  // Row i of R transposed is column i of R
  assign rot_idx = 4'({2'b00, xj_r} * 4'd3) + {2'b00, xi_r};

  // Angle to quadrant and folded octant
  assign phase  = {ang_r[ang_idx_r], {(32 - AW){1'b0}}};
  assign frac   = phase[29:0];
  assign fold   = frac > 30'h2000_0000;
  assign r_fold = fold ? 30'({1'b1, 30'd0} - {1'b0, frac}) : frac;

  // Round the series to coefficient precision and apply the quadrant
  always_comb begin
    s_sum = {1'b0, t_r} + SC_HALF;
    c_sum = {1'b0, u_r} + SC_HALF;
    sv = $signed({1'b0, s_sum[30-F +: F+1]});
    cv = $signed({1'b0, c_sum[30-F +: F+1]});
    sq = fold_r ? cv : sv;
    cq = fold_r ? sv : cv;
    case (quad_r)
      2'd0:    begin sin_fin = sq;  cos_fin = cq;  end
      2'd1:    begin sin_fin = cq;  cos_fin = -sq; end
      2'd2:    begin sin_fin = -sq; cos_fin = -cq; end
      default: begin sin_fin = -cq; cos_fin = sq;  end
    endcase
  end

  // Rounded product, accumulate and clamp for the matrix
  always_comb begin
    m_full = prod_r + MHALF;
    mq     = m_full[F +: F+3];
    case (mop.mode)
      MM_ADD:  msum = macc_r + mq;
      MM_SUB:  msum = macc_r - mq;
      default: msum = mq;
    endcase
    if (msum > COEF_ONE) begin
      mclamp = ROT_ONE;
    end else if (msum < -COEF_ONE) begin
      mclamp = -ROT_ONE;
    end else begin
      mclamp = msum[CFW-1:0];
    end
  end

  // Round and saturate one transform output
  always_comb begin
    xr = (xacc_r + XHALF) >>> F;
    if (xr > SAT_HI) begin
      xsat = SAT_HI;
    end else if (xr < SAT_LO) begin
      xsat = SAT_LO;
    end else begin
      xsat = xr;
    end
  end

  // Differences against the stored vehicle state
  assign vx = $signed({{(DW-CW){item_x[CW-1]}}, item_x});
  assign vy = $signed({{(DW-CW){item_y[CW-1]}}, item_y});
  assign vz = $signed({item_z[ZW-1], item_z});
  always_comb begin
    if (item_mode == MODE_TPOS) begin
      bx = $signed({{(DW-CW){pos_r[0][CW-1]}}, pos_r[0]});
      by = $signed({{(DW-CW){pos_r[1][CW-1]}}, pos_r[1]});
      bz = $signed({{(DW-CW){pos_r[2][CW-1]}}, pos_r[2]});
    end else begin
      bx = $signed({{(DW-CW){vel_r[0][CW-1]}}, vel_r[0]});
      by = $signed({{(DW-CW){vel_r[1][CW-1]}}, vel_r[1]});
      bz = $signed({{(DW-CW){vel_r[2][CW-1]}}, vel_r[2]});
    end
  end

  // Control and stored vehicle state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      ts_r      <= TS_X;
      ang_idx_r <= 2'd0;
      ms_r      <= 4'd0;
      xi_r      <= 2'd0;
      xj_r      <= 2'd0;
      for (int k = 0; k < 3; k++) begin
        pos_r[k] <= '0;
        vel_r[k] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        rot_r[k] <= (k % 4 == 0) ? ROT_ONE : '0;
      end
    end else begin
      state_r <= state_nxt;
      case (state_r)
        BK_IDLE: begin
          ang_idx_r <= 2'd0;
          ms_r      <= 4'd0;
          xi_r      <= 2'd0;
          xj_r      <= 2'd0;
          if (item_valid && item_mode == MODE_POSE) begin
            pos_r[0] <= item_x;
            pos_r[1] <= item_y;
            pos_r[2] <= item_z[CW-1:0];
          end
          if (item_valid && item_mode == MODE_VEL) begin
            vel_r[0] <= item_x;
            vel_r[1] <= item_y;
            vel_r[2] <= item_z[CW-1:0];
          end
        end
        BK_TRIG_SET: ts_r <= TS_X;
        BK_TRIG_POST: begin
          if (ts_r != TS_C4) begin
            ts_r <= trig_step_t'(ts_r + 4'd1);
          end
        end
        BK_TRIG_DONE: ang_idx_r <= ang_idx_r + 2'd1;
        BK_MAT_POST: begin
          if (mop.dst == MD_ROT) begin
            rot_r[mop.rot_idx] <= mclamp;
          end
          if (ms_r == MAT_LAST) begin
            rot_r[6] <= -sth_r;
          end
          ms_r <= ms_r + 4'd1;
        end
        BK_XF_POST: begin
          if (xj_r != 2'd2) begin
            xj_r <= xj_r + 2'd1;
          end
        end
        BK_XF_RND: begin
          xj_r <= 2'd0;
          xi_r <= xi_r + 2'd1;
        end
        default: begin
          ms_r <= ms_r;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod;
    case (state_r)
      BK_IDLE: begin
        if (item_valid) begin
          mode_r   <= item_mode;
          ang_r[0] <= item_roll;
          ang_r[1] <= item_pitch;
          ang_r[2] <= item_yaw;
          d_r[0]   <= vx - bx;
          d_r[1]   <= vy - by;
          d_r[2]   <= vz - bz;
        end
      end
      BK_TRIG_SET: begin
        quad_r <= phase[31:30];
        fold_r <= fold;
        r_r    <= r_fold;
      end
      BK_TRIG_POST: begin
        case (ts_r)
          TS_X:   x_r  <= prod_r[31 +: 30];
          TS_X2:  x2_r <= prod_r[30 +: 30];
          TS_S1:  t_r  <= ONE_Q30 - {1'b0, prod_r[36 +: 30]};
          TS_S2:  t_r  <= ONE_Q30 - {1'b0, prod_r[35 +: 30]};
          TS_S3:  t_r  <= ONE_Q30 - {1'b0, prod_r[33 +: 30]};
          TS_SIN: t_r  <= prod_r[30 +: 31];
          TS_C1:  u_r  <= ONE_Q30 - {1'b0, prod_r[36 +: 30]};
          TS_C2:  u_r  <= ONE_Q30 - {1'b0, prod_r[35 +: 30]};
          TS_C3:  u_r  <= ONE_Q30 - {1'b0, prod_r[34 +: 30]};
          TS_C4:  u_r  <= ONE_Q30 - {1'b0, prod_r[31 +: 30]};
          default: w_r <= prod_r[30 +: 30];
        endcase
      end
      BK_TRIG_DONE: begin
        case (ang_idx_r)
          2'd0:    begin sph_r <= sin_fin; cph_r <= cos_fin; end
          2'd1:    begin sth_r <= sin_fin; cth_r <= cos_fin; end
          default: begin sps_r <= sin_fin; cps_r <= cos_fin; end
        endcase
      end
      BK_MAT_POST: begin
        case (mop.dst)
          MD_A:    a_r    <= msum[CFW-1:0];
          MD_B:    b_r    <= msum[CFW-1:0];
          MD_ACC:  macc_r <= msum;
          default: macc_r <= macc_r;
        endcase
      end
      BK_XF_POST: begin
        xacc_r <= (xj_r == 2'd0) ? prod_r[SW-1:0] : xacc_r + prod_r[SW-1:0];
      end
      BK_XF_RND: res_r[xi_r] <= xsat[CW-1:0];
      default: begin
        xacc_r <= xacc_r;
      end
    endcase
  end

  assign res_kind = (mode_r == MODE_TVEL) ? KIND_VEL : KIND_POS;
  assign res_x    = res_r[0];
  assign res_y    = res_r[1];
  assign res_z    = res_r[2];
endmodule

>>> hw/rtl/euler_frame_change_transform.sv
// Top level of the Euler frame change transform: front part, back part and
// result queue. Depends on eft_pkg, eft_queue, eft_front and eft_back.
//
// Channel   Direction  Handshake                  Payload
// in_       input      push / full                mode, vec_x/y/z, roll/pitch/yaw angles
// out_      output     empty / pop                result_kind, body_x/y/z
// cfg_      input      valid / ready (always 1)   height offset, Q16.16
//
// A target item is handled in the back part as three outputs, each three
// multiply/accumulate pairs plus a round and saturate step, then a step to queue
// the result that waits while the result queue is full. A vehicle pose runs the
// series for each angle and then the matrix build through the shared multiplier.
// A vehicle velocity is stored while idle and gives no result. Two-entry queues
// on both sides of the back part keep input and result stalls apart.
// Reset: synchronous, active low; the matrix returns to identity, the stored
// vehicle vectors to zero and the height offset to 0.4 m.
`timescale 1ns / 1ps
module euler_frame_change_transform
  import eft_pkg::*;
#(
  parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
  parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [31:0]            cfg_data,
  // Input items
  input  logic                   in_push,
  output logic                   in_full,
  input  logic [1:0]             in_mode,
  input  logic [COORD_WIDTH-1:0] in_vec_x,
  input  logic [COORD_WIDTH-1:0] in_vec_y,
  input  logic [COORD_WIDTH-1:0] in_vec_z,
  input  logic [ANGLE_WIDTH-1:0] in_roll_angle,
  input  logic [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic [ANGLE_WIDTH-1:0] in_yaw_angle,
  // Results
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic                   out_result_kind,
  output logic [COORD_WIDTH-1:0] out_body_x,
  output logic [COORD_WIDTH-1:0] out_body_y,
  output logic [COORD_WIDTH-1:0] out_body_z
);
  localparam int CW = COORD_WIDTH;
  localparam int AW = ANGLE_WIDTH;
  localparam int ZW = ((CW > 32) ? CW : 32) + 1;
  localparam int RW = 1 + 3 * CW;

  // Front to back transaction
  logic                 item_valid, item_take;
  logic [1:0]           item_mode;
  logic [CW-1:0]        item_x, item_y;
  logic [ZW-1:0]        item_z;
  logic [AW-1:0]        item_roll, item_pitch, item_yaw;

  // Back to result queue
  logic                 res_full, res_push, res_kind;
  logic [CW-1:0]        res_x, res_y, res_z;
  logic [RW-1:0]        res_word, out_word;

  // Configuration is taken on any cycle; the user is to write it only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  eft_front #(
    .COORD_WIDTH (CW),
    .ANGLE_WIDTH (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_vec_x       (in_vec_x),
    .in_vec_y       (in_vec_y),
    .in_vec_z       (in_vec_z),
    .in_roll_angle  (in_roll_angle),
    .in_pitch_angle (in_pitch_angle),
    .in_yaw_angle   (in_yaw_angle),
    .item_valid     (item_valid),
    .item_take      (item_take),
    .item_mode      (item_mode),
    .item_x         (item_x),
    .item_y         (item_y),
    .item_z         (item_z),
    .item_roll      (item_roll),
    .item_pitch     (item_pitch),
    .item_yaw       (item_yaw)
  );

  eft_back #(
    .COORD_WIDTH    (CW),
    .ANGLE_WIDTH    (AW),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item_mode  (item_mode),
    .item_x     (item_x),
    .item_y     (item_y),
    .item_z     (item_z),
    .item_roll  (item_roll),
    .item_pitch (item_pitch),
    .item_yaw   (item_yaw),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_kind   (res_kind),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_z      (res_z)
  );

  // Hold finished results until the consumer pops them
  assign res_word = {res_kind, res_x, res_y, res_z};

  eft_queue #(.WIDTH(RW)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_word),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_word),
    .empty (out_empty)
  );

  assign {out_result_kind, out_body_x, out_body_y, out_body_z} = out_word;
endmodule
